// ----- rtl/tsmap_pkg.sv -----
// Package for the tick-to-nanosecond timestamp map.
// Holds the transaction payload types, calibration and pipeline types, and constants.
// No dependencies.
package tsmap_pkg;

    // Nanoseconds in one second; fits in 30 bits.
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Number of restoring division stages, one quotient bit each.
    localparam int DIV_STAGES = 64;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_REF_COUNT   = 2'd0;
    localparam logic [1:0] REG_TICK_RATE   = 2'd1;
    localparam logic [1:0] REG_REF_TIME    = 2'd2;
    localparam logic [1:0] REG_UNCERTAINTY = 2'd3;

    // Largest signed 64-bit value and magnitude of the smallest one.
    localparam logic [63:0] INT64_MAX_U   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] tick_value;
        logic [63:0] source_rate_hz;
    } tsmap_in_t;

    typedef struct packed {
        logic        ok;
        logic [62:0] mapped_time_ns;
        logic [63:0] uncertainty_out_ns;
    } tsmap_out_t;

    typedef struct packed {
        logic [63:0] reference_count;
        logic [63:0] tick_rate_hz;
        logic [63:0] reference_time_ns;
        logic [63:0] sample_uncertainty_ns;
    } tsmap_cal_t;

    // State of one item inside the divider.
    typedef struct packed {
        logic        live;
        logic        neg;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] num;
    } tsmap_div_t;

endpackage

// ----- rtl/tsmap_front.sv -----
// Front end of the timestamp map: checks, tick difference and the scaling product.
// Three register stages. Depends on tsmap_pkg.
module tsmap_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  tsmap_pkg::tsmap_in_t  in_data,
    input  tsmap_pkg::tsmap_cal_t cal,
    output logic                  out_valid,
    output tsmap_pkg::tsmap_div_t out_data
);
    import tsmap_pkg::*;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_live_reg, s1_neg_reg;
    logic [62:0] s1_mag_reg;
    logic        s2_live_reg, s2_neg_reg;
    logic [61:0] s2_plo_reg;
    logic [60:0] s2_phi_reg;
    tsmap_div_t  s3_reg;

    logic        s1_live_next, s1_neg_next;
    logic [63:0] mag;
    logic        cal_ok;
    logic [92:0] prod;
    tsmap_div_t  s3_next;

    // Stage 1: calibration and input checks, magnitude of the tick difference.
    always_comb
    begin
        cal_ok = (cal.reference_count != 64'd0) && (cal.tick_rate_hz != 64'd0) &&
                 !cal.reference_time_ns[63];
        s1_neg_next = in_data.tick_value < cal.reference_count;
        mag = s1_neg_next ? (cal.reference_count - in_data.tick_value)
                          : (in_data.tick_value - cal.reference_count);
        s1_live_next = cal_ok && (in_data.tick_value != 64'd0) &&
                       (in_data.source_rate_hz != 64'd0) &&
                       (in_data.source_rate_hz == cal.tick_rate_hz) && !mag[63];
    end

    // Stage 3: join the partial products and reject a quotient of 64 bits or more.
    always_comb
    begin
        prod = {31'd0, s2_plo_reg} + {s2_phi_reg, 32'd0};
        s3_next.live = s2_live_reg && ({35'd0, prod[92:64]} < cal.tick_rate_hz);
        s3_next.neg  = s2_neg_reg;
        s3_next.rem  = {35'd0, prod[92:64]};
        s3_next.quo  = 64'd0;
        s3_next.num  = prod[63:0];
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload of the three stages; stage 2 forms two partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_live_reg <= s1_live_next;
            s1_neg_reg  <= s1_neg_next;
            s1_mag_reg  <= mag[62:0];
            s2_live_reg <= s1_live_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_plo_reg  <= s1_mag_reg[31:0] * NS_PER_SEC;
            s2_phi_reg  <= s1_mag_reg[62:32] * NS_PER_SEC;
            s3_reg      <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;
endmodule

// ----- rtl/tsmap_div_stage.sv -----
// One stage of the pipelined restoring divider: settles one quotient bit.
// Depends on tsmap_pkg.
module tsmap_div_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [63:0]           divisor,
    input  logic                  in_valid,
    input  tsmap_pkg::tsmap_div_t in_data,
    output logic                  out_valid,
    output tsmap_pkg::tsmap_div_t out_data
);
    import tsmap_pkg::*;

    logic       valid_reg;
    tsmap_div_t data_reg;
    tsmap_div_t data_next;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    // Shift in the next numerator bit and subtract the divisor when it fits.
    always_comb
    begin
        trial = {in_data.rem, in_data.num[63]};
        diff  = trial - {1'b0, divisor};
        ge    = trial >= {1'b0, divisor};
        data_next.live = in_data.live;
        data_next.neg  = in_data.neg;
        data_next.rem  = ge ? diff[63:0] : trial[63:0];
        data_next.quo  = {in_data.quo[62:0], ge};
        data_next.num  = {in_data.num[62:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- rtl/tsmap_back.sv -----
// Back end of the timestamp map: range checks, the final add and the result register.
// Depends on tsmap_pkg.
module tsmap_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  tsmap_pkg::tsmap_div_t in_data,
    input  tsmap_pkg::tsmap_cal_t cal,
    output logic                  out_valid,
    output tsmap_pkg::tsmap_out_t out_data
);
    import tsmap_pkg::*;

    logic       valid_reg;
    tsmap_out_t data_reg;
    tsmap_out_t data_next;
    logic [63:0] sum;
    logic [63:0] q;
    logic        rem_nz;
    logic        good;

    // Range of the scaled difference, then the sum against the reference time.
    always_comb
    begin
        q      = in_data.quo;
        rem_nz = in_data.rem != 64'd0;
        if (!in_data.neg)
        begin
            sum  = cal.reference_time_ns + q;
            good = in_data.live && !((q > INT64_MAX_U) || ((q == INT64_MAX_U) && rem_nz)) &&
                   !sum[63];
        end
        else
        begin
            sum  = cal.reference_time_ns - q;
            good = in_data.live &&
                   !((q > INT64_MIN_MAG) || ((q == INT64_MIN_MAG) && rem_nz)) &&
                   !(q > cal.reference_time_ns);
        end
        data_next.ok                 = good;
        data_next.mapped_time_ns     = good ? sum[62:0] : 63'd0;
        data_next.uncertainty_out_ns = good ? cal.sample_uncertainty_ns : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- rtl/tick_to_nanosecond_timestamp_map.sv -----
// Tick-to-nanosecond timestamp map, top level: calibration registers and the pipeline.
// Depends on tsmap_pkg, tsmap_front, tsmap_div_stage and tsmap_back.
//
// The block takes one tick transaction per cycle while not stalled and returns one
// timestamp transaction for each, in order. The pipeline is made of three front stages
// (checks, partial products, product join), the 64-stage divider, each stage settling one
// quotient bit, and the result register. A stall on the output freezes the whole
// pipeline; the input stalls only while a result waits at the output. Calibration
// registers are written over the APB port and must only change while no transaction is
// in flight.
module tick_to_nanosecond_timestamp_map (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  tsmap_pkg::tsmap_in_t  tick_data,
    output logic                  time_valid,
    input  logic                  time_stall,
    output tsmap_pkg::tsmap_out_t time_data
);
    import tsmap_pkg::*;

    tsmap_cal_t cal_reg;
    logic       en;
    logic [1:0] reg_index;

    logic       div_valid [DIV_STAGES+1];
    tsmap_div_t div_data  [DIV_STAGES+1];

    // The pipeline moves unless a finished result is held at the output.
    assign en         = !(time_valid && time_stall);
    assign tick_stall = !en;
    assign pready     = 1'b1;
    assign reg_index  = paddr[4:3];

    // Calibration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_REF_COUNT:   cal_reg.reference_count       <= pwdata;
                REG_TICK_RATE:   cal_reg.tick_rate_hz          <= pwdata;
                REG_REF_TIME:    cal_reg.reference_time_ns     <= pwdata;
                REG_UNCERTAINTY: cal_reg.sample_uncertainty_ns <= pwdata;
                default:         cal_reg <= cal_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (reg_index)
            REG_REF_COUNT:   prdata = cal_reg.reference_count;
            REG_TICK_RATE:   prdata = cal_reg.tick_rate_hz;
            REG_REF_TIME:    prdata = cal_reg.reference_time_ns;
            REG_UNCERTAINTY: prdata = cal_reg.sample_uncertainty_ns;
            default:         prdata = 64'd0;
        endcase
    end

    tsmap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tick_valid),
        .in_data   (tick_data),
        .cal       (cal_reg),
        .out_valid (div_valid[0]),
        .out_data  (div_data[0])
    );

    // Chain of divider stages.
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        tsmap_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (cal_reg.tick_rate_hz),
            .in_valid  (div_valid[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    tsmap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .cal       (cal_reg),
        .out_valid (time_valid),
        .out_data  (time_data)
    );
endmodule

// ----- rtl/tsmap_checker.sv -----
// Port-level checker for the timestamp map, with its bind to the top level.
// Depends on tsmap_pkg and tick_to_nanosecond_timestamp_map.
module tsmap_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  tick_stall,
    input logic                  time_valid,
    input logic                  time_stall,
    input tsmap_pkg::tsmap_out_t time_data
);
    import tsmap_pkg::*;

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        time_valid && time_stall |=> time_valid && $stable(time_data))
        else $error("stalled result changed");

    // A rejected conversion carries zero fields.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        time_valid && !time_data.ok |->
            time_data.mapped_time_ns == 63'd0 && time_data.uncertainty_out_ns == 64'd0)
        else $error("rejected result has nonzero fields");

    // The input stalls only while a result waits on a stalled output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> time_valid && time_stall)
        else $error("input stalled without output backpressure");
endmodule

bind tick_to_nanosecond_timestamp_map tsmap_checker u_tsmap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_stall (tick_stall),
    .time_valid (time_valid),
    .time_stall (time_stall),
    .time_data  (time_data)
);
